// File: rtl/core/cuwa_pkg.sv
// shared types, constants and helpers for the cpu usage window average block
package cuwa_pkg;

  localparam int NUM_CPUS_DEF      = 4;
  localparam int HISTORY_DEPTH_DEF = 1024;
  localparam int MAX_CPUS          = 8;
  localparam int INPUT_LANES       = 4;
  localparam int PCT_W             = 7;
  localparam int MAX_PCT           = 100;
  localparam int Q_FRAC            = 8;
  localparam int AVG_W             = 15;
  localparam int AVG_MAX           = MAX_PCT << Q_FRAC;

  localparam logic [2:0] CPU_COUNT_RESET = 3'd4;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_UNSUPPORTED = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [PCT_W-1:0] util_lane0;
    logic [PCT_W-1:0] util_lane1;
    logic [PCT_W-1:0] util_lane2;
    logic [PCT_W-1:0] util_lane3;
    logic             all_cpus;
    logic [2:0]       cpu_select;
    logic [10:0]      window_steps;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [AVG_W-1:0] average_q8;
  } out_item_t;

  typedef struct packed {
    logic [2:0] cpu_count;
  } cfg_item_t;

  function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
    sat_pct = (v > PCT_W'(MAX_PCT)) ? PCT_W'(MAX_PCT) : v;
  endfunction

endpackage

// File: rtl/core/cuwa_stream_if.sv
// valid/ready channel interface carrying one payload item
interface cuwa_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/cuwa_history_mem.sv
// history memory: one word per ring position, one 7-bit entry per cpu lane
module cuwa_history_mem import cuwa_pkg::*; #(
  parameter int DEPTH  = HISTORY_DEPTH_DEF,
  parameter int LANES  = NUM_CPUS_DEF,
  parameter int ADDR_W = $clog2(HISTORY_DEPTH_DEF)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [LANES-1:0]            wr_lane_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [LANES-1:0][PCT_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [LANES-1:0][PCT_W-1:0] rd_data
);

  logic [LANES-1:0][PCT_W-1:0] mem_r [DEPTH];
  logic [LANES-1:0][PCT_W-1:0] rd_data_r;

  // per-lane write enables keep lanes outside the cpu count untouched
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (wr_en && wr_lane_en[i]) begin
        mem_r[wr_addr][i] <= wr_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/cuwa_divider.sv
// iterative restoring divider, one quotient bit per cycle
module cuwa_divider #(
  parameter int DIVD_W = 27,
  parameter int DIV_W  = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  rem_nxt;
  logic [DIVD_W-1:0] quo_r;
  logic [DIV_W-1:0]  dsr_r;
  logic [DIV_W:0]    trial;
  logic              bit_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DIVD_W-1]};
    bit_nxt = (trial >= {1'b0, dsr_r});
    rem_nxt = bit_nxt ? DIV_W'(trial - {1'b0, dsr_r}) : DIV_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVD_W);
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[DIVD_W-2:0], bit_nxt};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/core/cpu_usage_window_average.sv
// top level: per-cpu utilization ring with moving-window q8 averages
// sample transaction: written on acceptance, next transaction accepted the following cycle
// query transaction: one history memory read per window step, then the divider
//   produces one quotient bit per divider cycle
// unsupported cpu index: straight to the result, no history walk; one transaction is worked on at a time
// reset: clearing pass over every history position zeroes the history, no input taken meanwhile
module cpu_usage_window_average import cuwa_pkg::*; #(
  parameter int NUM_CPUS      = NUM_CPUS_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input logic           clk,
  input logic           rst_n,
  cuwa_stream_if.sink   in_chan,
  cuwa_stream_if.source out_chan,
  cuwa_stream_if.sink   cfg_chan
);

  localparam int ADDR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int LANE_W = $clog2(NUM_CPUS + 1);
  localparam int LSUM_W = $clog2(NUM_CPUS * MAX_PCT + 1);
  localparam int SUM_W  = $clog2(HISTORY_DEPTH * NUM_CPUS * MAX_PCT + 1);
  localparam int DIV_W  = $clog2(HISTORY_DEPTH * NUM_CPUS + 1);
  localparam int DIVD_W = SUM_W + Q_FRAC;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RESULT
  } state_t;

  state_t            state_r;
  logic [2:0]        cpu_count_r;
  logic [ADDR_W-1:0] wp_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [CNT_W-1:0]  remain_r;
  logic              rd_pend_r;
  logic              all_r;
  logic [2:0]        sel_r;
  logic [LANE_W-1:0] n_r;
  logic [CNT_W-1:0]  steps_r;
  logic [SUM_W-1:0]  sum_r;
  logic              status_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [LANE_W-1:0] n_use;
  logic              in_acc;
  logic              cfg_acc;
  logic [31:0]       win32;
  logic [CNT_W-1:0]  steps_in;
  logic              unsupported;

  logic [MAX_CPUS-1:0][PCT_W-1:0] util_pad;
  logic                           wr_en;
  logic [NUM_CPUS-1:0]            wr_lane_en;
  logic [ADDR_W-1:0]              wr_addr;
  logic [NUM_CPUS-1:0][PCT_W-1:0] wr_data;
  logic                           rd_en;
  logic [NUM_CPUS-1:0][PCT_W-1:0] rd_data;
  logic [LSUM_W-1:0]              lsum;

  logic [CNT_W+LANE_W-1:0] prod;
  logic                    div_start;
  logic                    div_done;
  logic [DIVD_W-1:0]       div_quo;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  // cpu count of zero counts as one, above the lane count saturates
  always_comb begin
    if (cpu_count_r == 3'd0) begin
      n_use = LANE_W'(1);
    end else if (32'(cpu_count_r) > NUM_CPUS) begin
      n_use = LANE_W'(NUM_CPUS);
    end else begin
      n_use = LANE_W'(cpu_count_r);
    end
  end

  always_comb begin
    win32 = 32'(in_chan.data.window_steps);
    if (win32 == 32'd0) begin
      steps_in = CNT_W'(1);
    end else if (win32 > 32'(HISTORY_DEPTH)) begin
      steps_in = CNT_W'(HISTORY_DEPTH);
    end else begin
      steps_in = CNT_W'(win32);
    end
    unsupported = !in_chan.data.all_cpus &&
                  (32'(in_chan.data.cpu_select) >= 32'(n_use));
  end

  // lanes without an input field write zero
  assign util_pad = {{((MAX_CPUS - INPUT_LANES) * PCT_W){1'b0}},
                     in_chan.data.util_lane3, in_chan.data.util_lane2,
                     in_chan.data.util_lane1, in_chan.data.util_lane0};

  always_comb begin
    wr_en   = (state_r == ST_CLEAR) || (in_acc && in_chan.data.kind == KIND_SAMPLE);
    wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : wp_r;
    for (int i = 0; i < NUM_CPUS; i++) begin
      if (state_r == ST_CLEAR) begin
        wr_lane_en[i] = 1'b1;
        wr_data[i]    = '0;
      end else begin
        wr_lane_en[i] = (i < 32'(n_use));
        wr_data[i]    = sat_pct(util_pad[i]);
      end
    end
  end

  assign rd_en = (state_r == ST_WALK) && (remain_r != '0);

  always_comb begin
    lsum = '0;
    for (int i = 0; i < NUM_CPUS; i++) begin
      if (all_r ? (i < 32'(n_r)) : (i == 32'(sel_r))) begin
        lsum = lsum + LSUM_W'(rd_data[i]);
      end
    end
  end

  assign prod      = steps_r * (all_r ? n_r : LANE_W'(1));
  assign div_start = (state_r == ST_DIV_GO);

  cuwa_history_mem #(
    .DEPTH  (HISTORY_DEPTH),
    .LANES  (NUM_CPUS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_lane_en (wr_lane_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr_r),
    .rd_data    (rd_data)
  );

  cuwa_divider #(
    .DIVD_W (DIVD_W),
    .DIV_W  (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_r, {Q_FRAC{1'b0}}}),
    .divisor  (DIV_W'(prod)),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cpu_count_r <= CPU_COUNT_RESET;
      wp_r        <= '0;
      rd_pend_r   <= 1'b0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_acc) begin
        cpu_count_r <= cfg_chan.data.cpu_count;
      end
      if (state_r == ST_RESULT && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      // read data lands in the cycle after the address
      rd_pend_r <= rd_en;
      if (rd_pend_r) begin
        sum_r <= sum_r + SUM_W'(lsum);
      end

      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == ADDR_W'(HISTORY_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (in_chan.data.kind == KIND_SAMPLE) begin
              wp_r <= (wp_r == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
            end else begin
              all_r     <= in_chan.data.all_cpus;
              sel_r     <= in_chan.data.cpu_select;
              n_r       <= n_use;
              steps_r   <= steps_in;
              remain_r  <= steps_in;
              rd_addr_r <= (wp_r == '0) ? ADDR_W'(HISTORY_DEPTH - 1) : wp_r - 1'b1;
              sum_r     <= '0;
              if (unsupported) begin
                status_r <= STATUS_UNSUPPORTED;
                state_r  <= ST_RESULT;
              end else begin
                status_r <= STATUS_OK;
                state_r  <= ST_WALK;
              end
            end
          end
        end
        ST_WALK: begin
          if (rd_en) begin
            rd_addr_r <= (rd_addr_r == '0) ? ADDR_W'(HISTORY_DEPTH - 1) : rd_addr_r - 1'b1;
            remain_r  <= remain_r - 1'b1;
          end
          if (remain_r == '0 && !rd_pend_r) begin
            state_r <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            state_r <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_data_r.status <= status_r;
            out_data_r.average_q8 <= (status_r == STATUS_UNSUPPORTED) ? '0 :
                                     div_quo[AVG_W-1:0];
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

// File: rtl/core/cuwa_checker.sv
// port-level assertions for the cpu usage window average block, with bind
module cuwa_checker import cuwa_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_kind,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_status,
  input logic [AVG_W-1:0] out_average_q8
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_average_q8))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_UNSUPPORTED |-> out_average_q8 == '0)
    else $error("unsupported status with nonzero average");

  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_average_q8) <= AVG_MAX)
    else $error("average above full scale");

  // a query transaction keeps the input closed while it is worked on
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_QUERY |=> !in_ready)
    else $error("input accepted right after a query");

endmodule

bind cpu_usage_window_average cuwa_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_kind        (in_chan.data.kind),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.data.status),
  .out_average_q8 (out_chan.data.average_q8)
);

// File: verif/cpu_usage_window_average_tb.sv
// testbench for cpu_usage_window_average: directed table, then random phases over cpu counts
`timescale 1ns / 1ps

module cpu_usage_window_average_tb;
  import cuwa_pkg::*;

  localparam int IDLE_LIMIT = 10000;
  localparam int TAIL_CYCLES = 1200;
  localparam int ITEMS_PER_PHASE = 72;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic sink_ready = 1'b0;
  bit   calm = 1'b0;
  int   stall_left = 0;
  int   stall_roll;
  int   idle_cycles = 0;
  int   mismatches = 0;

  // model state: history ring per cpu, shared write pointer, cpu count register
  logic [PCT_W-1:0] usage_hist [NUM_CPUS_DEF][HISTORY_DEPTH_DEF];
  int unsigned      wr_pos;
  logic [2:0]       cpu_count_reg;

  out_item_t pending_averages[$];
  dir_row_t  dir_rows[$];

  cuwa_stream_if #(.payload_t(in_item_t))  in_if ();
  cuwa_stream_if #(.payload_t(out_item_t)) out_if ();
  cuwa_stream_if #(.payload_t(cfg_item_t)) cfg_if ();

  assign out_if.ready = sink_ready;

  cpu_usage_window_average u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #4 clk = ~clk;

  function automatic int unsigned active_lanes();
    int unsigned n;
    n = cpu_count_reg;
    if (n == 0) n = 1;
    if (n > NUM_CPUS_DEF) n = NUM_CPUS_DEF;
    return n;
  endfunction

  function automatic out_item_t window_average(input in_item_t it);
    int unsigned n, steps, sel, pos, k, lane;
    longint unsigned total, divisor;
    out_item_t r;
    n = active_lanes();
    steps = it.window_steps;
    if (steps == 0) steps = 1;
    if (steps > HISTORY_DEPTH_DEF) steps = HISTORY_DEPTH_DEF;
    sel = it.cpu_select;
    r.status = STATUS_OK;
    r.average_q8 = '0;
    if (!it.all_cpus && sel >= n) begin
      r.status = STATUS_UNSUPPORTED;
      return r;
    end
    total = 0;
    pos = wr_pos;
    for (k = 0; k < steps; k++) begin
      // walk backward from the newest entry
      pos = (pos == 0) ? HISTORY_DEPTH_DEF - 1 : pos - 1;
      if (it.all_cpus) begin
        for (lane = 0; lane < n; lane++) total += usage_hist[lane][pos];
      end else begin
        total += usage_hist[sel][pos];
      end
    end
    divisor = longint'(steps) * (it.all_cpus ? n : 1);
    r.average_q8 = AVG_W'((total << Q_FRAC) / divisor);
    return r;
  endfunction

  task automatic record_sample(input in_item_t it);
    logic [PCT_W-1:0] rd [INPUT_LANES];
    int unsigned lane;
    rd[0] = it.util_lane0;
    rd[1] = it.util_lane1;
    rd[2] = it.util_lane2;
    rd[3] = it.util_lane3;
    for (lane = 0; lane < active_lanes(); lane++) begin
      usage_hist[lane][wr_pos] = (rd[lane] > MAX_PCT) ? PCT_W'(MAX_PCT) : rd[lane];
    end
    wr_pos = (wr_pos + 1) % HISTORY_DEPTH_DEF;
  endtask

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PCT_W-1:0] pick_pct();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return PCT_W'($urandom_range(0, MAX_PCT));
    if (roll < 90) return '0;
    return PCT_W'($urandom_range(MAX_PCT + 1, 127));
  endfunction

  function automatic in_item_t make_sample(input int l0, input int l1, input int l2,
                                           input int l3);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.kind = KIND_SAMPLE;
    it.util_lane0 = PCT_W'(l0);
    it.util_lane1 = PCT_W'(l1);
    it.util_lane2 = PCT_W'(l2);
    it.util_lane3 = PCT_W'(l3);
    return it;
  endfunction

  function automatic in_item_t make_query(input bit all, input int sel, input int win);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.kind = KIND_QUERY;
    it.all_cpus = all;
    it.cpu_select = 3'(sel);
    it.window_steps = 11'(win);
    return it;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed = 1'b0,
                                  input logic st = STATUS_OK, input int avg = 0);
    dir_row_t row;
    row.item = it;
    row.typed = typed;
    row.want.status = st;
    row.want.average_q8 = AVG_W'(avg);
    dir_rows.push_back(row);
  endfunction

  function automatic in_item_t random_item();
    int roll;
    int sel;
    int win;
    if ($urandom_range(0, 99) < 55) begin
      return make_sample(pick_pct(), pick_pct(), pick_pct(), pick_pct());
    end
    if ($urandom_range(0, 99) < 80) sel = $urandom_range(0, active_lanes() - 1);
    else sel = $urandom_range(0, 7);
    // mostly short windows, the long ones cost a history read per step
    roll = $urandom_range(0, 99);
    if (roll < 70) win = $urandom_range(1, 16);
    else if (roll < 88) win = $urandom_range(17, 128);
    else if (roll < 94) win = 0;
    else win = $urandom_range(129, 2047);
    return make_query($urandom_range(0, 1), sel, win);
  endfunction

  task automatic wait_drained();
    while (pending_averages.size() != 0) @(posedge clk);
  endtask

  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want,
                           input bit hold);
    int gap;
    gap = pick_gap();
    if (gap > 0 || hold) begin
      in_if.valid <= 1'b0;
      if (hold) begin
        @(posedge clk);
        wait_drained();
      end
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    if (it.kind == KIND_QUERY) begin
      pending_averages.push_back(typed ? want : window_average(it));
    end else begin
      record_sample(it);
    end
  endtask

  task automatic set_cpu_count(input logic [2:0] val);
    in_if.valid <= 1'b0;
    wait_drained();
    // a sample may still be in flight after the last result
    repeat (8) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data.cpu_count <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cpu_count_reg = val;
    cfg_if.valid <= 1'b0;
  endtask

  // result checking and stall watchdog
  always @(posedge clk) begin
    out_item_t exp_avg;
    if (rst_n && out_if.valid && sink_ready) begin
      if (pending_averages.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result status=%0d avg=%0d", out_if.data.status,
                   out_if.data.average_q8);
      end else begin
        exp_avg = pending_averages.pop_front();
        if (out_if.data.status !== exp_avg.status ||
            out_if.data.average_q8 !== exp_avg.average_q8) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: status exp %0d got %0d, avg exp %0d got %0d",
                     exp_avg.status, out_if.data.status, exp_avg.average_q8,
                     out_if.data.average_q8);
        end
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && sink_ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      sink_ready <= 1'b1;
      if (!calm) begin
        stall_roll = $urandom_range(0, 99);
        if (stall_roll >= 95) stall_left <= $urandom_range(10, 40);
        else if (stall_roll >= 75) stall_left <= $urandom_range(1, 3);
      end
    end
  end

  initial begin
    logic [2:0] phase_counts [8];
    out_item_t  none;
    int p, i;
    phase_counts = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd4, 3'd6};
    none = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    for (p = 0; p < NUM_CPUS_DEF; p++)
      for (i = 0; i < HISTORY_DEPTH_DEF; i++) usage_hist[p][i] = '0;
    wr_pos = 0;
    cpu_count_reg = CPU_COUNT_RESET;

    // cleared history, unsupported cpu, saturation, failed readings, window clamps
    add_row(make_query(1'b1, 5, 1), 1'b1, STATUS_OK, 0);
    add_row(make_query(1'b0, 7, 2047), 1'b1, STATUS_UNSUPPORTED, 0);
    add_row(make_query(1'b0, 4, 0), 1'b1, STATUS_UNSUPPORTED, 0);
    add_row(make_sample(100, 100, 100, 100));
    add_row(make_query(1'b0, 0, 1), 1'b1, STATUS_OK, 25600);
    add_row(make_sample(127, 101, 0, 50));
    add_row(make_query(1'b0, 0, 1), 1'b1, STATUS_OK, 25600);
    add_row(make_query(1'b0, 1, 1), 1'b1, STATUS_OK, 25600);
    add_row(make_query(1'b0, 2, 1), 1'b1, STATUS_OK, 0);
    add_row(make_query(1'b0, 3, 0), 1'b1, STATUS_OK, 12800);
    add_row(make_query(1'b0, 3, 2), 1'b1, STATUS_OK, 19200);
    add_row(make_sample(0, 0, 0, 0));
    add_row(make_query(1'b1, 0, 3));
    add_row(make_query(1'b1, 7, 1024));
    add_row(make_query(1'b1, 2, 2047));
    add_row(make_sample(1, 2, 4, 8));
    add_row(make_sample(16, 32, 64, 127));
    add_row(make_query(1'b0, 0, 1), 1'b1, STATUS_OK, 4096);
    add_row(make_query(1'b1, 6, 1), 1'b1, STATUS_OK, 13568);
    add_row(make_query(1'b0, 3, 1023));
    add_row(make_query(1'b0, 1, 1025));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want,
                                    1'b0);

    for (p = 0; p < 8; p++) begin
      set_cpu_count(phase_counts[p]);
      calm = (p == 2 || p == 5);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        push_item(random_item(), 1'b0, none, $urandom_range(0, 99) < 3);
      end
    end

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/cuwa_pkg.sv
rtl/core/cuwa_stream_if.sv
rtl/core/cuwa_history_mem.sv
rtl/core/cuwa_divider.sv
rtl/core/cpu_usage_window_average.sv
rtl/core/cuwa_checker.sv
verif/cpu_usage_window_average_tb.sv
